[rtl/core/rua_pkg.sv]
package rua_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_W   = 11;
  localparam int COORD_W = 11;

  // room for dimension compares up to 4096 and doubled coordinates
  localparam int DIM_W = 13;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

endpackage

[rtl/core/rua_ram.sv]
module rua_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write to the same entry return the old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[rtl/core/rgb_upscale_2x_average.sv]
// 2x enlargement of an rgb image by neighbor averaging. pixels of a
// width-by-height frame come in raster order; the enlarged frame is (2w-1) by
// (2h-1). each input item gives one to four results, one per cycle unless
// out_stall holds them: the copy, the left midpoint when the column is not the
// first, the upper midpoint when the row is not the first, and the four-pixel
// center when both hold; the final one carries last_of_item. an item has 1
// result on the first pixel of a frame, 2 on the rest of the first row and
// first column, 4 elsewhere; the single output register sends one result a
// cycle when not stalled. the previous row sits in a single line buffer ram that
// is read and rewritten at the same column in the cycle an item is taken.
// frame position counters are not cleared by a register write; the size
// registers should be written between frames.
module rgb_upscale_2x_average #(
  parameter int MAX_WIDTH  = rua_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rua_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rua_pkg::CFG_W-1:0]      cfg_data,
  // input pixel channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rua_pkg::CHAN_W-1:0]     red_in,
  input  logic [rua_pkg::CHAN_W-1:0]     green_in,
  input  logic [rua_pkg::CHAN_W-1:0]     blue_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rua_pkg::COORD_W-1:0]    out_row,
  output logic [rua_pkg::COORD_W-1:0]    out_col,
  output logic [rua_pkg::CHAN_W-1:0]     red_out,
  output logic [rua_pkg::CHAN_W-1:0]     green_out,
  output logic [rua_pkg::CHAN_W-1:0]     blue_out,
  output logic                           last_of_item
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CH    = rua_pkg::CHAN_W;
  localparam int PW    = rua_pkg::PIX_W;
  localparam int DW    = rua_pkg::DIM_W;

  // which result of an item is being sent
  typedef enum logic [1:0] {
    KIND_COPY   = 2'd0,
    KIND_LEFT   = 2'd1,
    KIND_UP     = 2'd2,
    KIND_CENTER = 2'd3
  } kind_t;

  // per-channel truncating averages
  function automatic logic [PW-1:0] avg2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW-1:0] r;
    logic [CH:0]   s;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      s = {1'b0, a[c*CH +: CH]} + {1'b0, b[c*CH +: CH]};
      r[c*CH +: CH] = s[CH:1];
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] avg4(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                          input logic [PW-1:0] c, input logic [PW-1:0] d);
    logic [PW-1:0] r;
    logic [CH+1:0] s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {2'b00, a[k*CH +: CH]} + {2'b00, b[k*CH +: CH]}
        + {2'b00, c[k*CH +: CH]} + {2'b00, d[k*CH +: CH]};
      r[k*CH +: CH] = s[CH+1:2];
    end
    return r;
  endfunction

  // configuration registers
  logic [rua_pkg::CFG_W-1:0] img_width;
  logic [rua_pkg::CFG_W-1:0] img_height;

  // frame position
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;

  // stage 0: item taken, line buffer read in flight
  logic          s0_valid;
  logic [PW-1:0] s0_pix;
  logic [CW-1:0] s0_col;
  logic [RW-1:0] s0_row;

  // neighbors carried from item to item
  logic [PW-1:0] left_pix;
  logic [PW-1:0] ul_pix;

  // stage 1: item being sent out, one result a cycle unless stalled
  logic          s1_valid;
  logic [PW-1:0] s1_cur;
  logic [PW-1:0] s1_left;
  logic [PW-1:0] s1_above;
  logic [PW-1:0] s1_ul;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic [1:0]    step;

  logic [PW-1:0] above;

  // handshake and flow
  logic          in_acc;
  logic          out_load;
  logic          s0_move;
  logic          s1_done;
  logic          s1_jpos;
  logic          s1_ipos;
  logic [1:0]    last_step;
  kind_t         kind;

  // effective frame size after clamping
  logic [DW-1:0] w_raw;
  logic [DW-1:0] h_raw;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic          col_last;
  logic          row_last;

  // result datapath
  logic [DW-1:0] row2;
  logic [DW-1:0] col2;
  logic [DW-1:0] row_sel;
  logic [DW-1:0] col_sel;
  logic [PW-1:0] pix_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= rua_pkg::IMAGE_WIDTH_RST;
      img_height <= rua_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rua_pkg::REG_IMAGE_WIDTH:  img_width  <= cfg_data;
        rua_pkg::REG_IMAGE_HEIGHT: img_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    w_raw = DW'(img_width);
    h_raw = DW'(img_height);
    if (w_raw == '0) begin
      w_eff = DW'(1);
    end else if (w_raw > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = DW'(1);
    end else if (h_raw > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // a counter already past a shrunken size wraps too
  assign col_last = (DW'(col_cnt) + DW'(1)) >= w_eff;
  assign row_last = (DW'(row_cnt) + DW'(1)) >= h_eff;

  // flow control: stage 0 hands over when stage 1 is empty or sends its last result
  assign out_load  = !out_valid || !out_stall;
  assign s1_jpos   = s1_col != '0;
  assign s1_ipos   = s1_row != '0;
  assign last_step = {s1_ipos && s1_jpos, s1_ipos || s1_jpos};
  assign s1_done   = s1_valid && out_load && (step == last_step);
  assign s0_move   = s0_valid && (!s1_valid || s1_done);
  assign in_stall  = s0_valid && !s0_move;
  assign in_acc    = in_valid && !in_stall;

  // line buffer: read the pixel above and store the current one in the same cycle
  rua_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_cnt),
    .wr_data ({red_in, green_in, blue_in}),
    .rd_en   (in_acc),
    .rd_addr (col_cnt),
    .rd_data (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_acc) begin
      s0_valid <= 1'b1;
    end else if (s0_move) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_pix <= {red_in, green_in, blue_in};
      s0_col <= col_cnt;
      s0_row <= row_cnt;
    end
  end

  // stage 1; ram data holds while stage 0 is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      step     <= '0;
    end else begin
      if (s0_move) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s0_move) begin
        step <= '0;
      end else if (s1_valid && out_load) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move) begin
      s1_cur   <= s0_pix;
      s1_above <= above;
      s1_left  <= left_pix;
      s1_ul    <= ul_pix;
      s1_col   <= s0_col;
      s1_row   <= s0_row;
      left_pix <= s0_pix;
      ul_pix   <= above;
    end
  end

  // result order: copy, left, up, center; the left one is skipped in column 0, up and center in row 0
  always_comb begin
    case (step)
      2'd0:    kind = KIND_COPY;
      2'd1:    kind = s1_jpos ? KIND_LEFT : KIND_UP;
      2'd2:    kind = KIND_UP;
      default: kind = KIND_CENTER;
    endcase
  end

  assign row2 = DW'({s1_row, 1'b0});
  assign col2 = DW'({s1_col, 1'b0});

  always_comb begin
    row_sel = row2;
    col_sel = col2;
    pix_sel = s1_cur;
    case (kind)
      KIND_COPY: begin
        pix_sel = s1_cur;
      end
      KIND_LEFT: begin
        col_sel = col2 - DW'(1);
        pix_sel = avg2(s1_left, s1_cur);
      end
      KIND_UP: begin
        row_sel = row2 - DW'(1);
        pix_sel = avg2(s1_above, s1_cur);
      end
      KIND_CENTER: begin
        row_sel = row2 - DW'(1);
        col_sel = col2 - DW'(1);
        pix_sel = avg4(s1_ul, s1_above, s1_left, s1_cur);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_row      <= row_sel[rua_pkg::COORD_W-1:0];
      out_col      <= col_sel[rua_pkg::COORD_W-1:0];
      red_out      <= pix_sel[2*CH +: CH];
      green_out    <= pix_sel[CH +: CH];
      blue_out     <= pix_sel[0 +: CH];
      last_of_item <= step == last_step;
    end
  end

endmodule

[rtl/core/rua_checker.sv]
module rua_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rua_pkg::COORD_W-1:0]   out_row,
  input logic [rua_pkg::COORD_W-1:0]   out_col,
  input logic [rua_pkg::CHAN_W-1:0]    red_out,
  input logic [rua_pkg::CHAN_W-1:0]    green_out,
  input logic [rua_pkg::CHAN_W-1:0]    blue_out,
  input logic                          last_of_item
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a center pixel (odd row and odd column) is always the final result of its item
  a_center_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_row[0] && out_col[0] |-> last_of_item)
    else $error("center result not marked last");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_row) && $stable(out_col) && $stable(red_out)
      && $stable(green_out) && $stable(blue_out) && $stable(last_of_item))
    else $error("stalled result changed");

endmodule

bind rgb_upscale_2x_average rua_checker u_rua_checker (.*);
